### hdl/rwcs_pkg.sv
// Shared types and constants for the raycaster wall column setup block.
package rwcs_pkg;

	localparam int COS_TABLE_BITS_DEF = 10;

	// Cosine table entries are |cos| in Q16, 0..65536
	localparam int COS_W = 17;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_TILE_SIZE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PROJ_DIST     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VIEWER_ANGLE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT    = 3'd5;

	localparam logic [10:0] TILE_SIZE_RST     = 11'd64;
	localparam logic [11:0] SCREEN_HEIGHT_RST = 12'd600;
	localparam logic [23:0] PROJ_DIST_RST     = 24'd221696;
	localparam logic [15:0] VIEWER_ANGLE_RST  = 16'd0;
	localparam logic [10:0] TEX_WIDTH_RST     = 11'd64;
	localparam logic [10:0] TEX_HEIGHT_RST    = 11'd64;

	localparam logic [25:0] SAT26      = 26'h3FFFFFF;
	localparam logic [15:0] STRIP_SAT  = 16'hFFFF;

	localparam logic [1:0] FACE_NORTH = 2'd0;
	localparam logic [1:0] FACE_SOUTH = 2'd1;
	localparam logic [1:0] FACE_EAST  = 2'd2;
	localparam logic [1:0] FACE_WEST  = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ROM,
		S_MUL,
		S_LOAD,
		S_DIV,
		S_FIN
	} state_t;

	// Divider jobs, run in this order
	typedef enum logic [1:0] {
		OP_STRIP,
		OP_STEP,
		OP_MOD,
		OP_QTW
	} div_op_t;

endpackage

### hdl/raycast_wall_column_setup.sv
// Top level of the raycaster wall column setup block.
// One ray (one screen column) is taken at a time. After a word is accepted the
// block reads the cosine table into a register, forms the perpendicular
// distance and the strip numerator in a multiply state, then runs four jobs
// through a single shared restoring divider that retires one quotient bit per
// cycle: strip height (16 bits), texture row step (26 bits), hit coordinate
// modulo tile (16 bits) and texture width over tile (11 bits). Each job has a
// load state and then one divide step per quotient bit. The strip divide or
// the row step divide is skipped when that value saturates, which shortens the
// column. in_ready is high only while the block is idle; the result sits in an
// output register, so a new ray can be accepted while the previous result
// waits. Configuration writes are always taken.
module raycast_wall_column_setup #(
	parameter int COS_TABLE_BITS = rwcs_pkg::COS_TABLE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rwcs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rwcs_pkg::CFG_DATA_W-1:0] cfg_data,

	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [23:0]                    ray_dist,
	input  logic [15:0]                    ray_dir_angle,
	input  logic                           hit_on_vertical,
	input  logic [15:0]                    hit_x,
	input  logic [15:0]                    hit_y,
	input  logic                           faces_up,
	input  logic                           faces_down,
	input  logic                           faces_right,
	input  logic                           faces_left,

	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [15:0]                    strip_height,
	output logic [11:0]                    top_row,
	output logic [11:0]                    bottom_row,
	output logic [19:0]                    tex_col,
	output logic [1:0]                     wall_face,
	output logic [25:0]                    tex_row_start,
	output logic [25:0]                    tex_row_step
);

	localparam int COS_N   = 1 << COS_TABLE_BITS;
	localparam int COS_Q   = COS_N >> 2;
	localparam int ROUND   = 1 << (15 - COS_TABLE_BITS);
	localparam int ADDR_W  = COS_TABLE_BITS - 1;
	localparam int ROM_W   = (COS_Q + 1) * rwcs_pkg::COS_W;

	// Signed quotient truncated toward zero, positive divisor, elaboration only
	function automatic longint div_trunc(longint a, longint d);
		logic [63:0] mag;
		logic [63:0] den;
		logic [63:0] rem;
		logic [63:0] quo;
		mag = (a < 0) ? 64'(-a) : 64'(a);
		den = 64'(d);
		rem = '0;
		quo = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], mag[b]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[b] = 1'b1;
			end
		end
		return (a < 0) ? -longint'(quo) : longint'(quo);
	endfunction

	// Quarter-wave cosine table, entries 0..COS_Q, built at elaboration
	function automatic logic [ROM_W-1:0] build_cos_rom();
		logic [ROM_W-1:0] rom;
		logic [63:0]      x;
		logic [63:0]      x2u;
		longint           x2;
		longint           term;
		longint           sum;
		longint           val;
		rom = '0;
		for (int k = 0; k <= COS_Q; k++) begin
			x    = (64'(k) * rwcs_pkg::HALF_PI_Q30) >> (COS_TABLE_BITS - 2);
			x2u  = (x * x) >> 30;
			x2   = longint'(x2u);
			term = 64'sd1 <<< 30;
			sum  = term;
			for (int n = 1; n <= 10; n++) begin
				term = -div_trunc(term * x2, 64'sd1 <<< 30);
				term = div_trunc(term, longint'((2 * n - 1) * (2 * n)));
				sum  = sum + term;
			end
			if (sum < 0)
				sum = 0;
			if (sum > (64'sd1 <<< 30))
				sum = 64'sd1 <<< 30;
			val = (sum + 64'sd8192) >>> 14;
			rom[k*rwcs_pkg::COS_W +: rwcs_pkg::COS_W] = val[rwcs_pkg::COS_W-1:0];
		end
		return rom;
	endfunction

	localparam logic [ROM_W-1:0] COS_ROM = build_cos_rom();

	// Configuration registers
	logic [10:0] tile_size_q;
	logic [11:0] screen_height_q;
	logic [23:0] proj_dist_q;
	logic [15:0] viewer_angle_q;
	logic [10:0] tex_width_q;
	logic [10:0] tex_height_q;

	// Control
	rwcs_pkg::state_t  state_q, state_d;
	rwcs_pkg::div_op_t op_q;
	logic              in_acc;
	logic              out_free;
	logic              load_skip;
	logic              div_last;
	logic [1:0]        current_face_q;
	logic [1:0]        face_d;
	logic              out_valid_q;

	// Item and working registers
	logic [23:0]                 dist_q;
	logic [15:0]                 ang_q;
	logic [15:0]                 coord_q;
	logic [rwcs_pkg::COS_W-1:0]  cos_q;
	logic [23:0]                 perp_q;
	logic [34:0]                 num_q;
	logic [15:0]                 strip_q;
	logic [25:0]                 step_q;
	logic [10:0]                 mod_q;
	logic [10:0]                 qtw_q;

	// Shared divider
	logic [23:0] div_rem_q;
	logic [25:0] div_num_q;
	logic [23:0] div_den_q;
	logic [4:0]  div_cnt_q;
	logic [24:0] div_trial;
	logic        div_ge;
	logic [23:0] div_rem_d;
	logic [25:0] div_num_d;

	// Output registers
	logic [15:0] o_strip_q;
	logic [11:0] o_top_q;
	logic [11:0] o_bot_q;
	logic [19:0] o_tcol_q;
	logic [1:0]  o_face_q;
	logic [25:0] o_start_q;
	logic [25:0] o_step_q;

	// Datapath helpers
	logic [10:0]               tile_eff;
	logic [15:0]               diff;
	logic [16:0]               idx_sum;
	logic [COS_TABLE_BITS-1:0] idx;
	logic [COS_TABLE_BITS-3:0] idx_r;
	logic [ADDR_W-1:0]         rom_addr;
	logic [41:0]               perp_prod;
	logic                      strip_sat;
	logic                      step_sat;
	logic [10:0]               half;
	logic [14:0]               hs;
	logic [11:0]               top_d;
	logic [15:0]               bot_sum;
	logic [11:0]               bot_d;
	logic [14:0]               dft;
	logic [40:0]               start_prod;
	logic [25:0]               start_d;
	logic [21:0]               tcol_prod;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == rwcs_pkg::S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign tile_eff  = (tile_size_q == 11'd0) ? 11'd1 : tile_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_size_q     <= rwcs_pkg::TILE_SIZE_RST;
			screen_height_q <= rwcs_pkg::SCREEN_HEIGHT_RST;
			proj_dist_q     <= rwcs_pkg::PROJ_DIST_RST;
			viewer_angle_q  <= rwcs_pkg::VIEWER_ANGLE_RST;
			tex_width_q     <= rwcs_pkg::TEX_WIDTH_RST;
			tex_height_q    <= rwcs_pkg::TEX_HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rwcs_pkg::REG_TILE_SIZE:     tile_size_q     <= cfg_data[10:0];
				rwcs_pkg::REG_SCREEN_HEIGHT: screen_height_q <= cfg_data[11:0];
				rwcs_pkg::REG_PROJ_DIST:     proj_dist_q     <= cfg_data[23:0];
				rwcs_pkg::REG_VIEWER_ANGLE:  viewer_angle_q  <= cfg_data[15:0];
				rwcs_pkg::REG_TEX_WIDTH:     tex_width_q     <= cfg_data[10:0];
				rwcs_pkg::REG_TEX_HEIGHT:    tex_height_q    <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// Face rules in priority order; keep the old face when none matches
	always_comb begin
		face_d = current_face_q;
		if (faces_up && !hit_on_vertical)
			face_d = rwcs_pkg::FACE_NORTH;
		else if (faces_down && !hit_on_vertical)
			face_d = rwcs_pkg::FACE_SOUTH;
		else if (faces_right && hit_on_vertical)
			face_d = rwcs_pkg::FACE_EAST;
		else if (faces_left && hit_on_vertical)
			face_d = rwcs_pkg::FACE_WEST;
	end

	// Table address: round the angle difference to the table grid, fold to a quarter
	assign diff     = ang_q - viewer_angle_q;
	assign idx_sum  = {1'b0, diff} + 17'(ROUND);
	assign idx      = idx_sum[16-COS_TABLE_BITS +: COS_TABLE_BITS];
	assign idx_r    = idx[COS_TABLE_BITS-3:0];
	assign rom_addr = idx[COS_TABLE_BITS-2] ? (ADDR_W'(COS_Q) - {1'b0, idx_r})
	                                        : {1'b0, idx_r};

	always_ff @(posedge clk) begin
		cos_q <= COS_ROM[int'(rom_addr) * rwcs_pkg::COS_W +: rwcs_pkg::COS_W];
	end

	assign perp_prod = 42'(dist_q) * 42'(cos_q) + 42'd32768;

	// Quotient would reach 2^16 (strip) or 2^26 (step): saturate without dividing
	assign strip_sat = (perp_q == 24'd0) || ({5'd0, num_q[34:16]} >= perp_q);
	assign step_sat  = (strip_q == 16'd0) || (tex_height_q[10] && (strip_q == 16'd1));
	assign load_skip = ((op_q == rwcs_pkg::OP_STRIP) && strip_sat) ||
	                   ((op_q == rwcs_pkg::OP_STEP) && step_sat);

	// One restoring step
	assign div_trial = {div_rem_q, div_num_q[25]};
	assign div_ge    = div_trial >= {1'b0, div_den_q};
	assign div_rem_d = div_ge ? 24'(div_trial - {1'b0, div_den_q}) : div_trial[23:0];
	assign div_num_d = {div_num_q[24:0], div_ge};
	assign div_last  = (div_cnt_q == 5'd1);

	// Row geometry and final products
	assign half       = screen_height_q[11:1];
	assign hs         = strip_q[15:1];
	assign top_d      = ({4'd0, half} >= hs) ? 12'({4'd0, half} - hs) : 12'd0;
	assign bot_sum    = 16'(half) + 16'(hs);
	assign bot_d      = (bot_sum > 16'(screen_height_q)) ? screen_height_q : bot_sum[11:0];
	assign dft        = (hs > 15'(half)) ? (hs - 15'(half)) : 15'd0;
	assign start_prod = 41'(dft) * 41'(step_q);
	assign start_d    = (start_prod > 41'(rwcs_pkg::SAT26)) ? rwcs_pkg::SAT26
	                                                         : start_prod[25:0];
	assign tcol_prod  = 22'(mod_q) * 22'(qtw_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= rwcs_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			rwcs_pkg::S_IDLE: begin
				if (in_valid)
					state_d = rwcs_pkg::S_ROM;
			end
			rwcs_pkg::S_ROM:  state_d = rwcs_pkg::S_MUL;
			rwcs_pkg::S_MUL:  state_d = rwcs_pkg::S_LOAD;
			rwcs_pkg::S_LOAD: begin
				if (!load_skip)
					state_d = rwcs_pkg::S_DIV;
			end
			rwcs_pkg::S_DIV: begin
				if (div_last)
					state_d = (op_q == rwcs_pkg::OP_QTW) ? rwcs_pkg::S_FIN
					                                     : rwcs_pkg::S_LOAD;
			end
			rwcs_pkg::S_FIN: begin
				if (out_free)
					state_d = rwcs_pkg::S_IDLE;
			end
			default: state_d = rwcs_pkg::S_IDLE;
		endcase
	end

	// Job sequence, face state and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q           <= rwcs_pkg::OP_STRIP;
			current_face_q <= rwcs_pkg::FACE_NORTH;
			out_valid_q    <= 1'b0;
		end else begin
			if (in_acc) begin
				op_q           <= rwcs_pkg::OP_STRIP;
				current_face_q <= face_d;
			end else if ((state_q == rwcs_pkg::S_LOAD && load_skip) ||
			             (state_q == rwcs_pkg::S_DIV && div_last &&
			              op_q != rwcs_pkg::OP_QTW)) begin
				op_q <= rwcs_pkg::div_op_t'(op_q + 2'd1);
			end
			if (state_q == rwcs_pkg::S_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			dist_q  <= ray_dist;
			ang_q   <= ray_dir_angle;
			coord_q <= hit_on_vertical ? hit_y : hit_x;
		end
		if (state_q == rwcs_pkg::S_MUL) begin
			perp_q <= perp_prod[39:16];
			num_q  <= 35'(tile_eff) * 35'(proj_dist_q);
		end
		if (state_q == rwcs_pkg::S_LOAD) begin
			case (op_q)
				rwcs_pkg::OP_STRIP: begin
					div_rem_q <= {5'd0, num_q[34:16]};
					div_num_q <= {num_q[15:0], 10'd0};
					div_den_q <= perp_q;
					div_cnt_q <= 5'd16;
					if (strip_sat)
						strip_q <= rwcs_pkg::STRIP_SAT;
				end
				rwcs_pkg::OP_STEP: begin
					div_rem_q <= {23'd0, tex_height_q[10]};
					div_num_q <= {tex_height_q[9:0], 16'd0};
					div_den_q <= {8'd0, strip_q};
					div_cnt_q <= 5'd26;
					if (step_sat)
						step_q <= rwcs_pkg::SAT26;
				end
				rwcs_pkg::OP_MOD: begin
					div_rem_q <= 24'd0;
					div_num_q <= {coord_q, 10'd0};
					div_den_q <= {13'd0, tile_eff};
					div_cnt_q <= 5'd16;
				end
				rwcs_pkg::OP_QTW: begin
					div_rem_q <= 24'd0;
					div_num_q <= {tex_width_q, 15'd0};
					div_den_q <= {13'd0, tile_eff};
					div_cnt_q <= 5'd11;
				end
				default: ;
			endcase
		end
		if (state_q == rwcs_pkg::S_DIV) begin
			div_rem_q <= div_rem_d;
			div_num_q <= div_num_d;
			div_cnt_q <= div_cnt_q - 5'd1;
			if (div_last) begin
				case (op_q)
					rwcs_pkg::OP_STRIP: strip_q <= div_num_d[15:0];
					rwcs_pkg::OP_STEP:  step_q  <= div_num_d;
					rwcs_pkg::OP_MOD:   mod_q   <= div_rem_d[10:0];
					rwcs_pkg::OP_QTW:   qtw_q   <= div_num_d[10:0];
					default: ;
				endcase
			end
		end
		if (state_q == rwcs_pkg::S_FIN && out_free) begin
			o_strip_q <= strip_q;
			o_top_q   <= top_d;
			o_bot_q   <= bot_d;
			o_tcol_q  <= tcol_prod[19:0];
			o_face_q  <= current_face_q;
			o_start_q <= start_d;
			o_step_q  <= step_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign strip_height  = o_strip_q;
	assign top_row       = o_top_q;
	assign bottom_row    = o_bot_q;
	assign tex_col       = o_tcol_q;
	assign wall_face     = o_face_q;
	assign tex_row_start = o_start_q;
	assign tex_row_step  = o_step_q;

endmodule

### tb/tb.sv
// Self-checking testbench for the raycaster wall column setup block.
`timescale 1ns / 100ps

module tb;

	localparam int COS_BITS = rwcs_pkg::COS_TABLE_BITS_DEF;
	localparam int COS_N = 1 << COS_BITS;
	localparam int COS_QTR = COS_N / 4;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint ONE_Q30 = 64'sd1073741824;
	localparam longint unsigned ROW_SAT = rwcs_pkg::SAT26;

	localparam logic [3:0] F_UP = 4'b1000;
	localparam logic [3:0] F_DOWN = 4'b0100;
	localparam logic [3:0] F_RIGHT = 4'b0010;
	localparam logic [3:0] F_LEFT = 4'b0001;

	localparam int PHASES = 10;
	localparam int RAYS_PER_PHASE = 110;
	localparam int HOLD_AT = 500;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic [23:0] ray_len;
		logic [15:0] angle;
		logic        vert;
		logic [15:0] hx;
		logic [15:0] hy;
		logic [3:0]  udrl;
	} ray_t;

	typedef struct {
		logic [15:0] strip;
		logic [11:0] top;
		logic [11:0] bot;
		logic [19:0] tcol;
		logic [1:0]  face;
		logic [25:0] start;
		logic [25:0] rstep;
	} column_t;

	typedef struct {
		bit          is_cfg;
		logic [2:0]  reg_idx;
		logic [23:0] reg_data;
		ray_t        ray;
		bit          known;
		column_t     want;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [rwcs_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [rwcs_pkg::CFG_DATA_W-1:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [23:0] ray_dist;
	logic [15:0] ray_dir_angle;
	logic        hit_on_vertical;
	logic [15:0] hit_x;
	logic [15:0] hit_y;
	logic        faces_up;
	logic        faces_down;
	logic        faces_right;
	logic        faces_left;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] strip_height;
	logic [11:0] top_row;
	logic [11:0] bottom_row;
	logic [19:0] tex_col;
	logic [1:0]  wall_face;
	logic [25:0] tex_row_start;
	logic [25:0] tex_row_step;

	// Shadow of the block's registers and face state
	logic [10:0] tile_r;
	logic [11:0] scr_h;
	logic [23:0] ppd;
	logic [15:0] view_angle;
	logic [10:0] tex_w;
	logic [10:0] tex_h;
	logic [1:0]  face_now;
	int unsigned cos_q16[COS_N];

	column_t columns_due[$];
	int mismatches = 0;
	int rays_sent = 0;
	int columns_seen = 0;

	raycast_wall_column_setup #(.COS_TABLE_BITS(COS_BITS)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.ray_dist(ray_dist),
		.ray_dir_angle(ray_dir_angle),
		.hit_on_vertical(hit_on_vertical),
		.hit_x(hit_x),
		.hit_y(hit_y),
		.faces_up(faces_up),
		.faces_down(faces_down),
		.faces_right(faces_right),
		.faces_left(faces_left),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.strip_height(strip_height),
		.top_row(top_row),
		.bottom_row(bottom_row),
		.tex_col(tex_col),
		.wall_face(wall_face),
		.tex_row_start(tex_row_start),
		.tex_row_step(tex_row_step)
	);

	always #2 clk = ~clk;

	// Taylor series of cos over one quarter wave, Q30, rounded to Q16
	function automatic int unsigned quarter_cos(int unsigned k);
		longint unsigned x;
		longint x2;
		longint term;
		longint acc;
		x = (64'(k) * HALF_PI_Q30) / COS_QTR;
		x2 = longint'((x * x) >> 30);
		term = ONE_Q30;
		acc = term;
		for (longint n = 1; n <= 10; n++) begin
			term = -((term * x2) / ONE_Q30);
			term = term / ((2 * n - 1) * (2 * n));
			acc += term;
		end
		if (acc < 0)
			acc = 0;
		if (acc > ONE_Q30)
			acc = ONE_Q30;
		return 32'((64'(acc) + 64'd8192) >> 14);
	endfunction

	function automatic void build_cos_table();
		int unsigned q;
		int unsigned rem;
		for (int i = 0; i < COS_N; i++) begin
			q = (i / COS_QTR) & 3;
			rem = i % COS_QTR;
			cos_q16[i] = quarter_cos(q[0] ? COS_QTR - rem : rem);
		end
	endfunction

	function automatic void reset_model();
		tile_r = rwcs_pkg::TILE_SIZE_RST;
		scr_h = rwcs_pkg::SCREEN_HEIGHT_RST;
		ppd = rwcs_pkg::PROJ_DIST_RST;
		view_angle = rwcs_pkg::VIEWER_ANGLE_RST;
		tex_w = rwcs_pkg::TEX_WIDTH_RST;
		tex_h = rwcs_pkg::TEX_HEIGHT_RST;
		face_now = rwcs_pkg::FACE_NORTH;
	endfunction

	function automatic column_t project_column(ray_t r);
		logic [15:0] diff;
		int unsigned idx;
		int unsigned tile;
		int unsigned half;
		int unsigned hs;
		int unsigned top;
		int unsigned bot;
		int unsigned coord;
		longint unsigned perp;
		longint unsigned strip;
		longint unsigned rstep;
		longint unsigned start;
		longint unsigned tcol;
		longint unsigned dft;
		column_t c;
		tile = (tile_r == 0) ? 1 : tile_r;
		diff = r.angle - view_angle;
		idx = ((32'(diff) + (1 << (15 - COS_BITS))) >> (16 - COS_BITS)) & (COS_N - 1);
		perp = (64'(r.ray_len) * cos_q16[idx] + 64'd32768) >> 16;
		if (perp == 0) begin
			strip = 65535;
		end else begin
			strip = (64'(tile) * 64'(ppd)) / perp;
			if (strip > 65535)
				strip = 65535;
		end
		half = scr_h / 2;
		hs = 32'(strip) / 2;
		top = (half >= hs) ? half - hs : 0;
		bot = half + hs;
		if (bot > scr_h)
			bot = scr_h;
		coord = r.vert ? r.hy : r.hx;
		tcol = 64'(coord % tile) * 64'(tex_w / tile);
		// First matching rule wins; no match keeps the last face
		if ((r.udrl & F_UP) != 0 && !r.vert)
			face_now = rwcs_pkg::FACE_NORTH;
		else if ((r.udrl & F_DOWN) != 0 && !r.vert)
			face_now = rwcs_pkg::FACE_SOUTH;
		else if ((r.udrl & F_RIGHT) != 0 && r.vert)
			face_now = rwcs_pkg::FACE_EAST;
		else if ((r.udrl & F_LEFT) != 0 && r.vert)
			face_now = rwcs_pkg::FACE_WEST;
		if (strip == 0) begin
			rstep = ROW_SAT;
		end else begin
			rstep = (64'(tex_h) << 16) / strip;
			if (rstep > ROW_SAT)
				rstep = ROW_SAT;
		end
		dft = 64'(top) + hs - half;
		start = dft * rstep;
		if (start > ROW_SAT)
			start = ROW_SAT;
		c.strip = strip[15:0];
		c.top = top[11:0];
		c.bot = bot[11:0];
		c.tcol = tcol[19:0];
		c.face = face_now;
		c.start = start[25:0];
		c.rstep = rstep[25:0];
		return c;
	endfunction

	function automatic plan_row_t reg_row(logic [2:0] idx, logic [23:0] data);
		plan_row_t p;
		p = '{default: '0};
		p.is_cfg = 1'b1;
		p.reg_idx = idx;
		p.reg_data = data;
		return p;
	endfunction

	function automatic plan_row_t ray_row(logic [23:0] ray_len, logic [15:0] angle, logic vert,
			logic [15:0] hx, logic [15:0] hy, logic [3:0] udrl);
		plan_row_t p;
		p = '{default: '0};
		p.ray = '{ray_len, angle, vert, hx, hy, udrl};
		return p;
	endfunction

	function automatic plan_row_t known_row(plan_row_t p, column_t want);
		p.known = 1'b1;
		p.want = want;
		return p;
	endfunction

	// Mostly in range, with the extremes and wide data now and then
	function automatic logic [23:0] pick_reg(int unsigned lo, int unsigned hi);
		case ($urandom_range(9, 0))
			0: return 24'(lo);
			1: return 24'(hi);
			2: return 24'($urandom);
			default: return 24'($urandom_range(hi, lo));
		endcase
	endfunction

	function automatic ray_t random_ray();
		ray_t r;
		int unsigned k;
		k = $urandom_range(24, 1);
		r.ray_len = 24'($urandom & ((1 << k) - 1));
		if ($urandom_range(4, 0) == 0)
			r.angle = 16'($urandom);
		else
			r.angle = view_angle + 16'($urandom_range(10922, 0)) - 16'd5461;
		r.vert = 1'($urandom_range(1, 0));
		r.hx = 16'($urandom);
		r.hy = 16'($urandom);
		if ($urandom_range(6, 0) == 0) begin
			r.udrl = 4'($urandom);
		end else begin
			// Well-formed: one of up/down and one of right/left
			r.udrl = $urandom_range(1, 0) ? F_UP : F_DOWN;
			r.udrl |= $urandom_range(1, 0) ? F_RIGHT : F_LEFT;
		end
		return r;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [23:0] data);
		if (in_valid)
			in_valid <= 1'b0;
		// Write only while the block is idle
		while (columns_due.size() != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			rwcs_pkg::REG_TILE_SIZE:     tile_r = data[10:0];
			rwcs_pkg::REG_SCREEN_HEIGHT: scr_h = data[11:0];
			rwcs_pkg::REG_PROJ_DIST:     ppd = data[23:0];
			rwcs_pkg::REG_VIEWER_ANGLE:  view_angle = data[15:0];
			rwcs_pkg::REG_TEX_WIDTH:     tex_w = data[10:0];
			rwcs_pkg::REG_TEX_HEIGHT:    tex_h = data[10:0];
			default: ;
		endcase
	endtask

	task automatic send_ray(ray_t r, bit known, column_t want);
		int gap;
		column_t col;
		gap = (rays_sent % 64 < 12) ? 0 : $urandom_range(7, 0);
		if (cfg_valid)
			cfg_valid <= 1'b0;
		if (gap > 0) begin
			if (in_valid)
				in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		ray_dist <= r.ray_len;
		ray_dir_angle <= r.angle;
		hit_on_vertical <= r.vert;
		hit_x <= r.hx;
		hit_y <= r.hy;
		{faces_up, faces_down, faces_right, faces_left} <= r.udrl;
		do @(posedge clk); while (in_ready !== 1'b1);
		col = project_column(r);
		columns_due.push_back(known ? want : col);
		rays_sent++;
	endtask

	task automatic check_field(string name, logic [25:0] exp, logic [25:0] got);
		if (got !== exp) begin
			$display("%0t: column %0d %s expected %0d actual %0d",
				$time, columns_seen, name, exp, got);
			mismatches++;
		end
	endtask

	initial begin
		plan_row_t plan[$];
		column_t none;
		none = '{default: '0};
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		ray_dist = '0;
		ray_dir_angle = '0;
		hit_on_vertical = 1'b0;
		hit_x = '0;
		hit_y = '0;
		faces_up = 1'b0;
		faces_down = 1'b0;
		faces_right = 1'b0;
		faces_left = 1'b0;
		build_cos_table();
		reset_model();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: strip of exactly one row, then a saturated strip
		plan.push_back(known_row(ray_row(24'd14188544, 16'd0, 1'b0, 16'd5, 16'd0, F_UP),
			'{16'd1, 12'd300, 12'd300, 20'd5, rwcs_pkg::FACE_NORTH, 26'd0, 26'd4194304}));
		plan.push_back(known_row(ray_row(24'd1, 16'd0, 1'b1, 16'd0, 16'hFFFF, F_RIGHT),
			'{rwcs_pkg::STRIP_SAT, 12'd0, 12'd600, 20'd63, rwcs_pkg::FACE_EAST,
			26'd2077888, 26'd64}));
		plan.push_back(ray_row(24'hFFFFFF, 16'hFFFF, 1'b0, 16'hFFFF, 16'hFFFF, 4'b1111));
		// Quarter turn off the heading, then a ray behind the viewer
		plan.push_back(ray_row(24'hFFFFFF, 16'd16384, 1'b0, 16'd100, 16'd7, F_DOWN));
		plan.push_back(ray_row(24'd1000, 16'd32768, 1'b1, 16'd3, 16'd200, F_LEFT));
		// No face rule matches: keep the previous face
		plan.push_back(ray_row(24'd5000, 16'd49152, 1'b0, 16'd77, 16'd9, F_RIGHT));
		plan.push_back(ray_row(24'd7000, 16'd1000, 1'b1, 16'd1, 16'd2, F_UP | F_DOWN));
		plan.push_back(ray_row(24'd0, 16'd0, 1'b0, 16'd0, 16'd0, 4'b0000));
		plan.push_back(ray_row(24'd300000, 16'd8192, 1'b1, 16'd0, 16'd12345, F_RIGHT | F_LEFT));
		plan.push_back(reg_row(rwcs_pkg::REG_VIEWER_ANGLE, 24'h00FFFF));
		plan.push_back(ray_row(24'd90000, 16'd0, 1'b0, 16'd64, 16'd0, F_UP));
		plan.push_back(ray_row(24'd90000, 16'h8000, 1'b1, 16'd0, 16'd65, F_LEFT));
		// Zero tile size, texture width and texture height
		plan.push_back(reg_row(rwcs_pkg::REG_TILE_SIZE, 24'd0));
		plan.push_back(reg_row(rwcs_pkg::REG_TEX_WIDTH, 24'd0));
		plan.push_back(reg_row(rwcs_pkg::REG_TEX_HEIGHT, 24'd0));
		plan.push_back(ray_row(24'd2000, 16'hFFF0, 1'b0, 16'd1234, 16'd0, F_DOWN));
		plan.push_back(ray_row(24'd20, 16'd100, 1'b1, 16'd0, 16'd4321, F_RIGHT));
		// Zero projection distance gives a zero strip height
		plan.push_back(reg_row(rwcs_pkg::REG_TILE_SIZE, 24'd64));
		plan.push_back(reg_row(rwcs_pkg::REG_TEX_WIDTH, 24'd64));
		plan.push_back(reg_row(rwcs_pkg::REG_TEX_HEIGHT, 24'd64));
		plan.push_back(reg_row(rwcs_pkg::REG_VIEWER_ANGLE, 24'd0));
		plan.push_back(reg_row(rwcs_pkg::REG_PROJ_DIST, 24'd0));
		plan.push_back(known_row(ray_row(24'd1000, 16'd0, 1'b0, 16'd70, 16'd0, F_UP),
			'{16'd0, 12'd300, 12'd300, 20'd6, rwcs_pkg::FACE_NORTH, 26'd0,
			rwcs_pkg::SAT26}));
		// Wide data masked down to the register widths
		plan.push_back(reg_row(rwcs_pkg::REG_TILE_SIZE, 24'hFFFFFF));
		plan.push_back(reg_row(rwcs_pkg::REG_SCREEN_HEIGHT, 24'hFFFFFF));
		plan.push_back(reg_row(rwcs_pkg::REG_PROJ_DIST, 24'hFFFFFF));
		plan.push_back(reg_row(rwcs_pkg::REG_TEX_WIDTH, 24'hFFFFFF));
		plan.push_back(reg_row(rwcs_pkg::REG_TEX_HEIGHT, 24'hFFFFFF));
		plan.push_back(ray_row(24'hFFFFFF, 16'd0, 1'b0, 16'hFFFF, 16'd0, F_UP));
		plan.push_back(ray_row(24'd1, 16'd300, 1'b1, 16'd0, 16'hFFFF, F_LEFT));
		plan.push_back(ray_row(24'd4000000, 16'hF000, 1'b1, 16'd2046, 16'd2047, F_RIGHT));
		plan.push_back(reg_row(rwcs_pkg::REG_SCREEN_HEIGHT, 24'd0));
		plan.push_back(ray_row(24'd50000, 16'd10, 1'b0, 16'd500, 16'd0, F_DOWN));
		plan.push_back(reg_row(rwcs_pkg::REG_TILE_SIZE, 24'd1024));
		plan.push_back(reg_row(rwcs_pkg::REG_SCREEN_HEIGHT, 24'd1));
		plan.push_back(reg_row(rwcs_pkg::REG_PROJ_DIST, 24'd1));
		plan.push_back(reg_row(rwcs_pkg::REG_TEX_WIDTH, 24'd1024));
		plan.push_back(reg_row(rwcs_pkg::REG_TEX_HEIGHT, 24'd1024));
		plan.push_back(ray_row(24'd1, 16'd0, 1'b1, 16'd0, 16'd1023, F_RIGHT));
		plan.push_back(ray_row(24'd3000, 16'd2000, 1'b0, 16'd1025, 16'd0, F_UP));

		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				write_reg(plan[i].reg_idx, plan[i].reg_data);
			else
				send_ray(plan[i].ray, plan[i].known, plan[i].want);
		end

		for (int p = 0; p < PHASES; p++) begin
			write_reg(rwcs_pkg::REG_TILE_SIZE, pick_reg(1, 1024));
			write_reg(rwcs_pkg::REG_SCREEN_HEIGHT, pick_reg(1, 4095));
			write_reg(rwcs_pkg::REG_PROJ_DIST, pick_reg(1, 16777215));
			write_reg(rwcs_pkg::REG_VIEWER_ANGLE, pick_reg(0, 65535));
			write_reg(rwcs_pkg::REG_TEX_WIDTH, pick_reg(1, 1024));
			write_reg(rwcs_pkg::REG_TEX_HEIGHT, pick_reg(1, 1024));
			repeat (RAYS_PER_PHASE)
				send_ray(random_ray(), 1'b0, none);
		end
		in_valid <= 1'b0;

		while (columns_due.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin : drain_columns
		int gap;
		column_t got;
		column_t exp;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = (columns_seen % 50 < 10) ? 0 : $urandom_range(7, 0);
			// Hold off once for a long stretch so the block backs up
			if (columns_seen == HOLD_AT)
				gap = HOLD_CYCLES;
			if (gap > 0) begin
				if (out_ready)
					out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			got = '{strip_height, top_row, bottom_row, tex_col, wall_face,
				tex_row_start, tex_row_step};
			if (columns_due.size() == 0) begin
				$display("%0t: column word with nothing expected, strip_height %0d",
					$time, got.strip);
				mismatches++;
			end else begin
				exp = columns_due.pop_front();
				check_field("strip_height", 26'(exp.strip), 26'(got.strip));
				check_field("top_row", 26'(exp.top), 26'(got.top));
				check_field("bottom_row", 26'(exp.bot), 26'(got.bot));
				check_field("tex_col", 26'(exp.tcol), 26'(got.tcol));
				check_field("wall_face", 26'(exp.face), 26'(got.face));
				check_field("tex_row_start", exp.start, got.start);
				check_field("tex_row_step", exp.rstep, got.rstep);
			end
			columns_seen++;
		end
	end

	initial begin
		#3000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

### raycast_wall_column_setup.f
hdl/rwcs_pkg.sv
hdl/raycast_wall_column_setup.sv
tb/tb.sv
